// ----- design/dcp_pkg.sv -----
`timescale 1ns / 1ps

package dcp_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PAL_SIZE    = 4;

    typedef logic [23:0] t_color;

    // r<<16 | g<<8 | b, one row per palette_select code
    localparam t_color CGA_PAL [0:3][0:PAL_SIZE-1] = '{
        '{24'h000000, 24'h00AA00, 24'hAA0000, 24'hAA5500},
        '{24'h000000, 24'h55FF55, 24'hFF5555, 24'hFFFF55},
        '{24'h000000, 24'h00AAAA, 24'hAA00AA, 24'hAAAAAA},
        '{24'h000000, 24'h55FFFF, 24'hFF55FF, 24'hFFFFFF}
    };

    typedef struct packed {
        logic capture;  // latch the incoming word
        logic exec;     // look up, insert and load the result register
    } t_cmd;

    typedef struct packed {
        logic out_free; // result register empty or being drained
    } t_status;

endpackage

// ----- design/distinct_color_palette_detector.sv -----
`timescale 1ns / 1ps

// Distinct color counter: each RGB word is compared in parallel against up
// to 16 stored colors, inserted if new (or flags overflow when the store is
// full), and answered with its slot, new flag, color count, overflow flag and
// whether the seen set equals the CGA palette picked by i_cfg_data. A word
// with i_last_pixel set still gets its result, then the set is emptied. Each
// word is first latched, then looked up, inserted and compared against the
// palette from the store registers once the output register is free; the
// next word is taken while a result still waits in the output register.
// Write the palette select only while no word is in flight.
module distinct_color_palette_detector
    import dcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_last_pixel,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_slot_index,
    output logic       o_is_new,
    output logic [4:0] o_color_count,
    output logic       o_overflow,
    output logic       o_palette_matches
);

    t_cmd    cmd;
    t_status status;

    dcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dcp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_last_pixel      (i_last_pixel),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_slot_index      (o_slot_index),
        .o_is_new          (o_is_new),
        .o_color_count     (o_color_count),
        .o_overflow        (o_overflow),
        .o_palette_matches (o_palette_matches)
    );

endmodule

// ----- design/dcp_ctrl.sv -----
`timescale 1ns / 1ps

module dcp_ctrl
    import dcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_CALC) && i_status.out_free;
        n_state       = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CALC;
            end
            S_CALC: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.exec))
        else $error("capture and exec in the same cycle");

endmodule

// ----- design/dcp_datapath.sv -----
`timescale 1ns / 1ps

module dcp_datapath
    import dcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic             i_last_pixel,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [3:0]       o_slot_index,
    output logic             o_is_new,
    output logic [4:0]       o_color_count,
    output logic             o_overflow,
    output logic             o_palette_matches
);

    t_color             r_store [0:STORE_DEPTH-1];
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [1:0]         r_pal_sel;
    t_color             r_pix;
    logic               r_last;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_slot;
    logic               r_is_new;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_ovf;
    logic               r_out_pal;

    logic [STORE_DEPTH-1:0] hit;
    logic                   found;
    logic [IDX_W-1:0]       hit_slot;
    logic                   full;
    logic                   ins;
    logic [IDX_W-1:0]       n_slot;
    logic [CNT_W-1:0]       n_count;
    logic                   n_ovf;
    t_color                 post [0:PAL_SIZE-1];
    logic [PAL_SIZE-1:0]    pal_seen;
    logic                   n_pal;

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        hit      = '0;
        hit_slot = '0;
        for (int j = 0; j < STORE_DEPTH; j++) begin
            hit[j] = (CNT_W'(j) < r_count) && (r_store[j] == r_pix);
        end
        // entries are distinct, so at most one hit
        for (int j = STORE_DEPTH - 1; j >= 0; j--) begin
            if (hit[j]) hit_slot = IDX_W'(j);
        end
        found   = |hit;
        full    = (r_count == CNT_W'(STORE_DEPTH));
        ins     = !found && !full;
        n_slot  = found ? hit_slot : (ins ? r_count[IDX_W-1:0] : '0);
        n_count = r_count + CNT_W'(ins);
        n_ovf   = r_ovf || (!found && full);

        // first entries as they stand after this word's insert
        for (int k = 0; k < PAL_SIZE; k++) begin
            post[k] = (ins && r_count == CNT_W'(k)) ? r_pix : r_store[k];
        end
        pal_seen = '0;
        for (int p = 0; p < PAL_SIZE; p++) begin
            for (int k = 0; k < PAL_SIZE; k++) begin
                if (post[k] == CGA_PAL[r_pal_sel][p]) pal_seen[p] = 1'b1;
            end
        end
        n_pal = !n_ovf && (n_count == CNT_W'(PAL_SIZE)) && (&pal_seen);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix  <= {i_red, i_green, i_blue};
            r_last <= i_last_pixel;
        end
        if (i_cmd.exec) begin
            if (ins) r_store[r_count[IDX_W-1:0]] <= r_pix;
            r_slot      <= n_slot;
            r_is_new    <= ins;
            r_out_count <= n_count;
            r_out_ovf   <= n_ovf;
            r_out_pal   <= n_pal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pal_sel   <= 2'd3;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_pal_sel <= i_cfg_data;
            if (i_cmd.exec) begin
                // end of image: store is emptied by dropping the count
                r_count     <= r_last ? '0 : n_count;
                r_ovf       <= r_last ? 1'b0 : n_ovf;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_slot_index      = 4'(r_slot);
    assign o_is_new          = r_is_new;
    assign o_color_count     = 5'(r_out_count);
    assign o_overflow        = r_out_ovf;
    assign o_palette_matches = r_out_pal;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("color count beyond store depth");

    a_new_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_is_new |->
            (r_out_count == CNT_W'(r_slot) + CNT_W'(1)) && !r_out_ovf)
        else $error("new color not placed at the top slot");

    a_pal_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pal |-> r_out_count == CNT_W'(PAL_SIZE) && !r_out_ovf)
        else $error("palette match with wrong color count");

    a_exec_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("result register not loaded");

endmodule

// ----- dv/tb_distinct_color_palette_detector.sv -----
`timescale 1ns / 1ps

module tb_distinct_color_palette_detector
    import dcp_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_ITEMS   = 175;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } px_word_t;

    typedef struct packed {
        logic [3:0] slot;
        logic       is_new;
        logic [4:0] count;
        logic       ovf;
        logic       pal_hit;
    } px_report_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic       i_last_pixel = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_slot_index;
    logic       o_is_new;
    logic [4:0] o_color_count;
    logic       o_overflow;
    logic       o_palette_matches;

    distinct_color_palette_detector i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_last_pixel     (i_last_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_slot_index     (o_slot_index),
        .o_is_new         (o_is_new),
        .o_color_count    (o_color_count),
        .o_overflow       (o_overflow),
        .o_palette_matches(o_palette_matches)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the color set
    t_color     color_store [STORE_DEPTH];
    logic [4:0] color_cnt = '0;
    logic       ovf_flag = 1'b0;
    logic [1:0] pal_sel = 2'd3;

    px_word_t   pixel_q [$];
    px_report_t expected_reports_q [$];
    px_word_t   cur_word;
    px_report_t got_report;
    px_report_t exp_report;

    int  send_idle_pct = 24;
    int  recv_idle_pct = 73;
    int  hold_req_cnt = 0;
    int  hold_ack_cnt = 0;
    int  hold_left = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  in_fire = 1'b0;

    function automatic px_report_t track_pixel(px_word_t w);
        t_color     c;
        px_report_t rep;
        bit         hit;
        bit         found;
        c = {w.r, w.g, w.b};
        rep = '0;
        hit = 1'b0;
        for (int j = 0; j < STORE_DEPTH; j++) begin
            if (!hit && j < color_cnt && color_store[j] == c) begin
                hit = 1'b1;
                rep.slot = 4'(j);
            end
        end
        if (!hit) begin
            if (color_cnt < STORE_DEPTH) begin
                rep.slot = 4'(color_cnt);
                color_store[color_cnt] = c;
                color_cnt = color_cnt + 5'd1;
                rep.is_new = 1'b1;
            end else begin
                rep.slot = '0;
                ovf_flag = 1'b1;
            end
        end
        rep.count = color_cnt;
        rep.ovf = ovf_flag;
        rep.pal_hit = !ovf_flag && color_cnt == PAL_SIZE;
        for (int k = 0; k < PAL_SIZE; k++) begin
            found = 1'b0;
            for (int j = 0; j < STORE_DEPTH; j++) begin
                if (j < color_cnt && color_store[j] == CGA_PAL[pal_sel][k])
                    found = 1'b1;
            end
            if (!found)
                rep.pal_hit = 1'b0;
        end
        if (w.last) begin
            color_cnt = '0;
            ovf_flag = 1'b0;
        end
        return rep;
    endfunction

    task automatic report_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
                     act_val);
        end
    endtask

    // monitor and scoreboard
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_report = '{o_slot_index, o_is_new, o_color_count, o_overflow,
                           o_palette_matches};
            if (expected_reports_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected word, expected none actual %h", $time, got_report);
            end else begin
                exp_report = expected_reports_q.pop_front();
                report_field("slot_index", exp_report.slot, got_report.slot);
                report_field("is_new", exp_report.is_new, got_report.is_new);
                report_field("color_count", exp_report.count, got_report.count);
                report_field("overflow", exp_report.ovf, got_report.ovf);
                report_field("palette_matches", exp_report.pal_hit, got_report.pal_hit);
            end
        end
        if (in_fire)
            expected_reports_q = {expected_reports_q,
                track_pixel('{i_red, i_green, i_blue, i_last_pixel})};
    end

    // pixel driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_word = pixel_q.pop_front();
                i_red <= cur_word.r;
                i_green <= cur_word.g;
                i_blue <= cur_word.b;
                i_last_pixel <= cur_word.last;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result sink, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_color rand_color();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    task automatic add_pixel(t_color c, logic last);
        px_word_t w;
        w = '{c[23:16], c[15:8], c[7:0], last};
        pixel_q = {pixel_q, w};
    endtask

    // palette-heavy image: mostly colors of the selected palette
    task automatic add_palette_image(output int n);
        int     len;
        t_color c;
        len = $urandom_range(4, 10);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: c = CGA_PAL[$urandom_range(3)][$urandom_range(PAL_SIZE - 1)];
                1: c = rand_color();
                default: c = CGA_PAL[pal_sel][$urandom_range(PAL_SIZE - 1)];
            endcase
            add_pixel(c, i == len - 1);
        end
        n = len;
    endtask

    // image drawn from a small random pool, big pools overflow the store
    task automatic add_pool_image(output int n);
        t_color pool [20];
        int     pool_sz;
        int     len;
        pool_sz = $urandom_range(1, 20);
        len = $urandom_range(1, 40);
        for (int i = 0; i < 20; i++)
            pool[i] = rand_color();
        for (int i = 0; i < len; i++)
            add_pixel(pool[$urandom_range(pool_sz - 1)], i == len - 1);
        n = len;
    endtask

    task automatic add_noise(output int n);
        int len;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
            add_pixel(24'($urandom()), $urandom_range(9) == 0);
        n = len;
    endtask

    task automatic fill_random(int target);
        int total;
        int n;
        total = 0;
        while (total < target) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: add_palette_image(n);
                5, 6, 7: add_pool_image(n);
                default: add_noise(n);
            endcase
            total += n;
        end
    endtask

    task automatic write_palette_sel(logic [1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        pal_sel = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || expected_reports_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // exact palette match, then a repeat that ends the image
        write_palette_sel(2'd3);
        for (int k = 0; k < PAL_SIZE; k++)
            add_pixel(CGA_PAL[3][k], 1'b0);
        add_pixel(CGA_PAL[3][1], 1'b1);
        // fill the store, then a new color with the store full, then a known one
        for (int i = 0; i < STORE_DEPTH; i++)
            add_pixel({8'(i * 17), 8'hFF - 8'(i * 17), 8'(i)}, 1'b0);
        add_pixel(24'hFFFFFF, 1'b0);
        add_pixel(24'h00FF00, 1'b1);
        wait_drained();

        write_palette_sel(2'd0);
        fill_random(SEG_ITEMS);
        wait_drained();

        send_idle_pct = 73;
        recv_idle_pct = 24;
        write_palette_sel(2'd1);
        fill_random(SEG_ITEMS);
        wait_drained();

        write_palette_sel(2'd2);
        fill_random(SEG_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_palette_sel(2'd3);
        fill_random(SEG_ITEMS);
        hold_req_cnt++;
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
